FILE: sv/decimal_accumulator_machine_core_assert.svh
// Assertion macros for the decimal accumulator machine core.
`ifndef DECIMAL_ACCUMULATOR_MACHINE_CORE_ASSERT_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DAM_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define DAM_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define DAM_ASSERT_IMP(lbl, a, b)
`define DAM_ASSERT_NEXT(lbl, a, b)
`endif
`endif

FILE: sv/dam_pkg.sv
// Shared constants, codes and control structs of the decimal accumulator machine.
package dam_pkg;
  localparam int MEM_DEPTH = 128;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int PW = $clog2(MEM_DEPTH + 1);
  localparam int WORD_MAX = 9999;
  localparam int WORD_MIN = -9999;
  localparam int RECIP_100 = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int DIV_BITS = 14;

  typedef enum logic [3:0] {
    ST_LOADED   = 4'd0,
    ST_LOAD_REJ = 4'd1,
    ST_EXEC     = 4'd2,
    ST_WRITE    = 4'd3,
    ST_NEWLINE  = 4'd4,
    ST_HALTED   = 4'd5,
    ST_READ_REJ = 4'd6,
    ST_OVERFLOW = 4'd7,
    ST_DIVZERO  = 4'd8,
    ST_BADOP    = 4'd9,
    ST_BADADDR  = 4'd10
  } status_t;

  localparam logic [6:0] OP_READ    = 7'd10;
  localparam logic [6:0] OP_WRITE   = 7'd11;
  localparam logic [6:0] OP_LOAD    = 7'd20;
  localparam logic [6:0] OP_STORE   = 7'd21;
  localparam logic [6:0] OP_ADD     = 7'd30;
  localparam logic [6:0] OP_SUB     = 7'd31;
  localparam logic [6:0] OP_DIV     = 7'd32;
  localparam logic [6:0] OP_MUL     = 7'd33;
  localparam logic [6:0] OP_BR      = 7'd40;
  localparam logic [6:0] OP_BRNEG   = 7'd41;
  localparam logic [6:0] OP_BRZERO  = 7'd42;
  localparam logic [6:0] OP_HALT    = 7'd43;
  localparam logic [6:0] OP_REM     = 7'd44;
  localparam logic [6:0] OP_NEWLINE = 7'd46;

  typedef struct packed {
    logic accept;
    logic start;
    logic decode;
    logic operand;
    logic execute;
    logic mul_check;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic fetch;
    logic is_mul;
    logic is_div;
    logic div_last;
  } sts_t;
endpackage

FILE: sv/dam_if.sv
// Valid/ready channel interfaces for input items and result items.
interface dam_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] word_in;
  modport source (output valid, mode, word_in, input ready);
  modport sink (input valid, mode, word_in, output ready);
endinterface

interface dam_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic signed [14:0] out_value;
  logic [6:0]         out_address;
  logic signed [14:0] accumulator_now;
  logic [7:0]         counter_now;
  logic signed [14:0] instruction_word;
  modport source (output valid, status, out_value, out_address, accumulator_now,
                  counter_now, instruction_word, input ready);
  modport sink (input valid, status, out_value, out_address, accumulator_now,
                counter_now, instruction_word, output ready);
endinterface

FILE: sv/dam_ctrl.sv
// Sequencing state machine of the decimal accumulator machine.
module dam_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_ready,
  input  dam_pkg::sts_t sts,
  output dam_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_valid
);
  import dam_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_START  = 8'b00000010,
    S_DECODE = 8'b00000100,
    S_OPER   = 8'b00001000,
    S_EXEC   = 8'b00010000,
    S_MUL    = 8'b00100000,
    S_DIV    = 8'b01000000,
    S_RESP   = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        cmd.start = 1'b1;
        state_next = sts.fetch ? S_DECODE : S_RESP;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_OPER;
      end
      S_OPER: begin
        cmd.operand = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        if (sts.is_mul) state_next = S_MUL;
        else if (sts.is_div) state_next = S_DIV;
        else state_next = S_RESP;
      end
      S_MUL: begin
        cmd.mul_check = 1'b1;
        state_next = S_RESP;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);
endmodule

FILE: sv/dam_datapath.sv
// Word store, registers, arithmetic and iterative divider of the machine.
module dam_datapath (
  input  logic               clk,
  input  logic               rst,
  input  dam_pkg::cmd_t      cmd,
  output dam_pkg::sts_t      sts,
  input  logic               in_mode,
  input  logic signed [15:0] in_word,
  output logic [3:0]         status,
  output logic signed [14:0] out_value,
  output logic [6:0]         out_address,
  output logic signed [14:0] accumulator_now,
  output logic [7:0]         counter_now,
  output logic signed [14:0] instruction_word
);
  import dam_pkg::*;

  logic               mode_r;
  logic signed [15:0] word_r;
  logic signed [14:0] acc;
  logic [PW-1:0]      ic;
  logic [PW-1:0]      lp;
  logic               stopped;
  logic signed [14:0] ir;
  logic               ir_neg;
  logic [6:0]         opc;
  logic [6:0]         opd;
  logic signed [29:0] prod;

  logic signed [14:0] mem [MEM_DEPTH];
  logic signed [14:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic signed [14:0] wdata;

  logic [DIV_BITS-1:0] dq;
  logic [DIV_BITS-1:0] drem;
  logic [DIV_BITS-1:0] dvs;
  logic [3:0]          dcnt;
  logic                d_qneg;
  logic                d_rneg;
  logic                d_isrem;

  status_t            res_status;
  logic signed [14:0] res_value;
  logic [6:0]         res_addr;
  logic signed [14:0] res_ir;

  logic               word_ok;
  logic               lp_ok;
  logic [26:0]        recip_prod;
  logic [6:0]         opc_calc;
  logic [6:0]         opd_calc;
  logic signed [15:0] sum;
  logic               sum_ok;
  logic               prod_ok;
  logic               m_zero;
  logic [DIV_BITS:0]  d_trial;
  logic               d_bit;
  logic [DIV_BITS-1:0] dq_next;
  logic [DIV_BITS-1:0] drem_next;
  logic [DIV_BITS-1:0] acc_mag;
  logic [DIV_BITS-1:0] m_mag;

  assign word_ok  = (word_r >= WORD_MIN) && (word_r <= WORD_MAX);
  assign lp_ok    = lp < PW'(MEM_DEPTH);
  assign recip_prod = 27'(rdata[13:0]) * 27'(RECIP_100);
  assign opc_calc = 7'(recip_prod >> RECIP_SHIFT);
  assign opd_calc = ir_neg ? 7'd0 : 7'(14'(ir[13:0]) - 14'(opc) * 14'd100);
  assign sum      = (opc == OP_SUB) ? 16'(acc) - 16'(rdata) : 16'(acc) + 16'(rdata);
  assign sum_ok   = (sum >= WORD_MIN) && (sum <= WORD_MAX);
  assign prod_ok  = (prod >= WORD_MIN) && (prod <= WORD_MAX);
  assign m_zero   = (rdata == '0);
  assign acc_mag  = DIV_BITS'(acc < 0 ? -acc : acc);
  assign m_mag    = DIV_BITS'(rdata < 0 ? -rdata : rdata);

  // One restoring step: shift the next dividend bit into the partial remainder.
  assign d_trial   = {drem, dq[DIV_BITS-1]};
  assign d_bit     = d_trial >= {1'b0, dvs};
  assign drem_next = d_bit ? DIV_BITS'(d_trial - {1'b0, dvs}) : DIV_BITS'(d_trial);
  assign dq_next   = {dq[DIV_BITS-2:0], d_bit};

  assign sts.fetch    = mode_r && !stopped && (ic < PW'(MEM_DEPTH));
  assign sts.is_mul   = !ir_neg && (opc == OP_MUL);
  assign sts.is_div   = !ir_neg && ((opc == OP_DIV) || (opc == OP_REM)) && !m_zero;
  assign sts.div_last = (dcnt == 4'(DIV_BITS - 1));

  always_comb begin
    raddr = AW'(opd_calc);
    if (cmd.start) raddr = ic[AW-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(opd);
    wdata = acc;
    if (cmd.start && !mode_r && word_ok && lp_ok) begin
      we    = 1'b1;
      waddr = lp[AW-1:0];
      wdata = 15'(word_r);
    end else if (cmd.execute && !ir_neg) begin
      if (opc == OP_READ && word_ok) begin
        we    = 1'b1;
        wdata = 15'(word_r);
      end else if (opc == OP_STORE) begin
        we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      word_r <= in_word;
    end
    if (cmd.decode) begin
      ir     <= rdata;
      ir_neg <= rdata < 0;
      opc    <= opc_calc;
    end
    if (cmd.operand) opd <= opd_calc;
    if (cmd.execute) begin
      prod    <= 30'(acc) * 30'(rdata);
      dq      <= acc_mag;
      drem    <= '0;
      dvs     <= m_mag;
      dcnt    <= '0;
      d_qneg  <= (acc < 0) != (rdata < 0);
      d_rneg  <= acc < 0;
      d_isrem <= opc == OP_REM;
    end
    if (cmd.div_step) begin
      dq   <= dq_next;
      drem <= drem_next;
      dcnt <= dcnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      ic      <= '0;
      lp      <= '0;
      stopped <= 1'b0;
    end else begin
      if (cmd.start) begin
        res_value <= '0;
        res_addr  <= '0;
        res_ir    <= '0;
        if (!mode_r) begin
          if (word_ok && lp_ok) begin
            lp         <= lp + PW'(1);
            res_status <= ST_LOADED;
          end else begin
            res_status <= ST_LOAD_REJ;
          end
        end else if (stopped) begin
          res_status <= ST_HALTED;
        end else if (!sts.fetch) begin
          res_status <= ST_BADADDR;
          stopped    <= 1'b1;
        end
      end
      if (cmd.execute) begin
        res_ir     <= ir;
        res_addr   <= opd;
        res_value  <= '0;
        res_status <= ST_EXEC;
        if (ir_neg) begin
          res_status <= ST_BADOP;
          stopped    <= 1'b1;
        end else begin
          unique case (opc)
            OP_READ: begin
              if (word_ok) ic <= ic + PW'(1);
              else res_status <= ST_READ_REJ;
            end
            OP_WRITE: begin
              res_value  <= rdata;
              res_status <= ST_WRITE;
              ic         <= ic + PW'(1);
            end
            OP_LOAD: begin
              acc <= rdata;
              ic  <= ic + PW'(1);
            end
            OP_STORE: ic <= ic + PW'(1);
            OP_ADD, OP_SUB: begin
              if (sum_ok) begin
                acc <= 15'(sum);
                ic  <= ic + PW'(1);
              end else begin
                res_status <= ST_OVERFLOW;
                stopped    <= 1'b1;
              end
            end
            OP_MUL: ;
            OP_DIV, OP_REM: begin
              if (m_zero) begin
                res_status <= ST_DIVZERO;
                stopped    <= 1'b1;
              end
            end
            OP_BR: ic <= PW'(opd);
            OP_BRNEG: ic <= (acc < 0) ? PW'(opd) : ic + PW'(1);
            OP_BRZERO: ic <= (acc == '0) ? PW'(opd) : ic + PW'(1);
            OP_HALT: begin
              res_status <= ST_HALTED;
              stopped    <= 1'b1;
            end
            OP_NEWLINE: begin
              res_status <= ST_NEWLINE;
              ic         <= ic + PW'(1);
            end
            default: begin
              res_status <= ST_BADOP;
              stopped    <= 1'b1;
            end
          endcase
        end
      end
      if (cmd.mul_check) begin
        if (prod_ok) begin
          acc <= 15'(prod);
          ic  <= ic + PW'(1);
        end else begin
          res_status <= ST_OVERFLOW;
          stopped    <= 1'b1;
        end
      end
      if (cmd.div_step && sts.div_last) begin
        if (d_isrem) acc <= d_rneg ? -15'(drem_next) : 15'(drem_next);
        else acc <= d_qneg ? -15'(dq_next) : 15'(dq_next);
        ic <= ic + PW'(1);
      end
    end
  end

  assign status           = res_status;
  assign out_value        = res_value;
  assign out_address      = res_addr;
  assign accumulator_now  = acc;
  assign counter_now      = 8'(ic);
  assign instruction_word = res_ir;
endmodule

FILE: sv/decimal_accumulator_machine_core.sv
// Top level of the decimal accumulator machine: controller, datapath and checks.
//
// Items arrive on in_ch (mode, word_in) and each gives exactly one result item
// on out_ch. Mode 0 loads word_in into the next word-store location; mode 1
// executes the instruction at the instruction counter.
// The block works on one item at a time: in_ch.ready is high only while idle.
// Path from acceptance to out_ch.valid: a load, a step on a stopped machine or a
// bad counter goes through the start state only; most instructions go through fetch,
// decode by reciprocal multiply, operand read and execute; multiply adds a state
// in which its registered product gets its range check; divide and remainder add
// the 14 steps of the restoring divider. After each delivered result the controller
// returns to its idle state before it takes the next item.
// The result waits in registers while out_ch.ready is low, and no new item is
// taken until it is delivered.
// Reset clears the accumulator, instruction counter, load pointer and stop
// flag; the word store is not cleared and must be written before it is read.
`include "decimal_accumulator_machine_core_assert.svh"
module decimal_accumulator_machine_core (
  input logic      clk,
  input logic      rst,
  dam_in_if.sink   in_ch,
  dam_out_if.source out_ch
);
  import dam_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  dam_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_ch.mode),
    .in_word          (in_ch.word_in),
    .status           (out_ch.status),
    .out_value        (out_ch.out_value),
    .out_address      (out_ch.out_address),
    .accumulator_now  (out_ch.accumulator_now),
    .counter_now      (out_ch.counter_now),
    .instruction_word (out_ch.instruction_word)
  );

  `DAM_ASSERT_IMP(a_no_overlap, out_ch.valid, !in_ch.ready)
  `DAM_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `DAM_ASSERT_NEXT(a_one_result, out_ch.valid && out_ch.ready, !out_ch.valid)
endmodule

FILE: test/decimal_accumulator_machine_core_tb.sv
// Self-checking testbench for the decimal accumulator machine core.
`timescale 1ns / 1ps

module decimal_accumulator_machine_core_tb;
  import dam_pkg::*;

  localparam int TOTAL_ITEMS = 1800;
  localparam int TAIL_START  = TOTAL_ITEMS - 40;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 25;
  localparam int DATA_LO     = 10;
  localparam int DATA_HI     = 89;
  localparam int SLOT        = 1;

  typedef struct {
    logic [3:0]         status;
    logic signed [14:0] value;
    logic [6:0]         address;
    logic signed [14:0] acc;
    logic [7:0]         counter;
    logic signed [14:0] instr;
  } step_result_t;

  typedef struct {
    logic               mode;
    logic signed [15:0] word;
    logic               has_status;
    status_t            status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dam_in_if  in_ch ();
  dam_out_if out_ch ();

  decimal_accumulator_machine_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Machine state as the predictor sees it.
  int  mem_words [MEM_DEPTH];
  int  acc_q;
  int  ctr_q;
  int  load_ptr;
  bit  halted_q;

  step_result_t expected_results [$];
  int  errors;
  int  phase;
  int  idle_cycles;
  int  status_seen [11];
  int  accepted_items;

  // Plans for the closing sequence that drives the machine into a stop.
  int  tail_instrs [$];
  int  tail_values [$];

  stim_row_t directed_rows [] = '{
    '{1'b0, 16'sd32767,  1'b1, ST_LOAD_REJ},
    '{1'b0, -16'sd32768, 1'b1, ST_LOAD_REJ},
    '{1'b0, 16'sd10000,  1'b1, ST_LOAD_REJ},
    '{1'b0, -16'sd10000, 1'b1, ST_LOAD_REJ},
    '{1'b0, 16'sd1001,   1'b1, ST_LOADED},
    '{1'b0, 16'sd4600,   1'b1, ST_LOADED},
    '{1'b0, 16'sd4000,   1'b1, ST_LOADED},
    '{1'b1, -16'sd32768, 1'b1, ST_READ_REJ},
    '{1'b1, 16'sd32767,  1'b1, ST_READ_REJ},
    '{1'b1, -16'sd10000, 1'b1, ST_READ_REJ},
    '{1'b1, 16'sd4600,   1'b1, ST_EXEC},
    '{1'b1, 16'sd0,      1'b1, ST_NEWLINE},
    '{1'b1, 16'sd0,      1'b1, ST_EXEC},
    '{1'b1, 16'sd4602,   1'b1, ST_EXEC},
    '{1'b1, -16'sd1,     1'b1, ST_NEWLINE},
    '{1'b1, 16'sd0,      1'b1, ST_EXEC},
    '{1'b0, 16'sd9999,   1'b1, ST_LOADED},
    '{1'b0, -16'sd9999,  1'b1, ST_LOADED}
  };

  function automatic bit in_word_range(int w);
    return w >= WORD_MIN && w <= WORD_MAX;
  endfunction

  // Advances the machine by one item and returns the result it gives.
  function automatic step_result_t run_machine(logic mode, logic signed [15:0] w_in);
    step_result_t r;
    int w, ir, opc, opd, m, t;
    w = int'(w_in);
    r = '{ST_EXEC, '0, '0, '0, '0, '0};
    if (!mode) begin
      if (!in_word_range(w) || load_ptr >= MEM_DEPTH) begin
        r.status = ST_LOAD_REJ;
      end else begin
        mem_words[load_ptr] = w;
        load_ptr++;
        r.status = ST_LOADED;
      end
    end else if (halted_q) begin
      r.status = ST_HALTED;
    end else if (ctr_q >= MEM_DEPTH) begin
      halted_q = 1'b1;
      r.status = ST_BADADDR;
    end else begin
      ir = mem_words[ctr_q];
      opc = ir / 100;
      opd = ir % 100;
      if (ir < 0) begin
        opc = -1;
        opd = 0;
      end
      m = mem_words[opd];
      case (opc)
        OP_READ: begin
          if (in_word_range(w)) begin
            mem_words[opd] = w;
            ctr_q++;
          end else begin
            r.status = ST_READ_REJ;
          end
        end
        OP_WRITE: begin
          r.value = 15'(m);
          r.status = ST_WRITE;
          ctr_q++;
        end
        OP_LOAD: begin
          acc_q = m;
          ctr_q++;
        end
        OP_STORE: begin
          mem_words[opd] = acc_q;
          ctr_q++;
        end
        OP_ADD, OP_SUB, OP_MUL: begin
          t = (opc == OP_ADD) ? acc_q + m : (opc == OP_SUB) ? acc_q - m : acc_q * m;
          if (in_word_range(t)) begin
            acc_q = t;
            ctr_q++;
          end else begin
            r.status = ST_OVERFLOW;
            halted_q = 1'b1;
          end
        end
        OP_DIV, OP_REM: begin
          if (m == 0) begin
            r.status = ST_DIVZERO;
            halted_q = 1'b1;
          end else begin
            acc_q = (opc == OP_DIV) ? acc_q / m : acc_q % m;
            ctr_q++;
          end
        end
        OP_BR: ctr_q = opd;
        OP_BRNEG: ctr_q = (acc_q < 0) ? opd : ctr_q + 1;
        OP_BRZERO: ctr_q = (acc_q == 0) ? opd : ctr_q + 1;
        OP_HALT: begin
          r.status = ST_HALTED;
          halted_q = 1'b1;
        end
        OP_NEWLINE: begin
          r.status = ST_NEWLINE;
          ctr_q++;
        end
        default: begin
          r.status = ST_BADOP;
          halted_q = 1'b1;
        end
      endcase
      r.address = 7'(opd);
      r.instr = 15'(ir);
    end
    r.acc = 15'(acc_q);
    r.counter = 8'(ctr_q);
    return r;
  endfunction

  function automatic int data_word();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return WORD_MAX;
      2: return WORD_MIN;
      3: return $urandom_range(0, 60) - 30;
      default: return $urandom_range(0, 2 * WORD_MAX) - WORD_MAX;
    endcase
  endfunction

  function automatic int wild_word();
    if ($urandom_range(0, 1))
      return 10000 + $urandom_range(0, 22767);
    return -10000 - $urandom_range(0, 22768);
  endfunction

  // An instruction that keeps the machine running from its current state.
  function automatic int running_instr();
    int a, m, t, kind, target;
    a = $urandom_range(DATA_LO, DATA_HI);
    m = mem_words[a];
    target = $urandom_range(0, 1) ? 0 : 2;
    kind = $urandom_range(0, 12);
    case (kind)
      0: return OP_READ * 100 + a;
      1: return OP_WRITE * 100 + a;
      2: return OP_LOAD * 100 + a;
      3: return OP_STORE * 100 + a;
      4, 5, 6: begin
        t = (kind == 4) ? acc_q + m : (kind == 5) ? acc_q - m : acc_q * m;
        if (!in_word_range(t))
          return OP_LOAD * 100 + a;
        return ((kind == 4) ? OP_ADD : (kind == 5) ? OP_SUB : OP_MUL) * 100 + a;
      end
      7, 8: begin
        if (m == 0)
          return OP_LOAD * 100 + a;
        return ((kind == 7) ? OP_DIV : OP_REM) * 100 + a;
      end
      9: return OP_BR * 100 + target;
      10: return OP_BRNEG * 100 + target;
      11: return OP_BRZERO * 100 + target;
      default: return OP_NEWLINE * 100 + a;
    endcase
  endfunction

  // The closing sequence ends in one of the ways the machine can stop.
  task automatic plan_stop();
    case ($urandom_range(0, 4))
      0: tail_instrs.push_back(OP_HALT * 100 + $urandom_range(0, 99));
      1: begin
        tail_instrs = '{OP_READ * 100 + DATA_LO, OP_LOAD * 100 + DATA_LO,
                        ($urandom_range(0, 1) ? OP_ADD : OP_MUL) * 100 + DATA_LO};
        tail_values.push_back(WORD_MAX);
      end
      2: begin
        tail_instrs = '{OP_READ * 100 + DATA_LO,
                        ($urandom_range(0, 1) ? OP_DIV : OP_REM) * 100 + DATA_LO};
        tail_values.push_back(0);
      end
      3: tail_instrs.push_back($urandom_range(0, 1) ? -$urandom_range(1, 9999) : 4500 + 200 *
                               $urandom_range(0, 1));
      default: tail_instrs.push_back(OP_BR * 100 + 90);
    endcase
  endtask

  // Picks the word for a step from the instruction about to be fetched.
  function automatic int step_word(bit closing);
    int ir;
    if (halted_q || ctr_q >= MEM_DEPTH)
      return $urandom_range(0, 65535);
    ir = mem_words[ctr_q];
    if (ir < 0 || ir / 100 != OP_READ)
      return $urandom_range(0, 65535);
    if (closing) begin
      if (ir % 100 == SLOT && tail_instrs.size() > 0)
        return tail_instrs.pop_front();
      if (ir % 100 != SLOT && tail_values.size() > 0)
        return tail_values.pop_front();
    end
    if ($urandom_range(0, 99) < 8)
      return wild_word();
    return (ir % 100 == SLOT) ? running_instr() : data_word();
  endfunction

  task automatic send_item(logic mode, logic signed [15:0] word, bit has_status,
                           status_t status);
    step_result_t r;
    int idle_pct;
    idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 73 : 19) : 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.word_in <= word;
    do @(posedge clk); while (!in_ch.ready);
    r = run_machine(mode, word);
    if (has_status)
      r.status = status;
    expected_results.push_back(r);
    accepted_items++;
  endtask

  task automatic report_field(string name, longint exp_v, longint got_v);
    $display("%0t: mismatch in %s: expected %0d, actual %0d", $realtime, name, exp_v, got_v);
    errors++;
  endtask

  // Result side: random stalls and comparison against the oldest expectation.
  always @(posedge clk) begin
    step_result_t e;
    int stall_pct;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $realtime, out_ch.status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.status < 11)
          status_seen[out_ch.status]++;
        if (out_ch.status !== e.status)
          report_field("status", e.status, out_ch.status);
        if (out_ch.out_value !== e.value)
          report_field("out_value", e.value, out_ch.out_value);
        if (out_ch.out_address !== e.address)
          report_field("out_address", e.address, out_ch.out_address);
        if (out_ch.accumulator_now !== e.acc)
          report_field("accumulator_now", e.acc, out_ch.accumulator_now);
        if (out_ch.counter_now !== e.counter)
          report_field("counter_now", e.counter, out_ch.counter_now);
        if (out_ch.instruction_word !== e.instr)
          report_field("instruction_word", e.instr, out_ch.instruction_word);
      end
    end
    stall_pct = (phase == 2) ? 73 : (phase == 3) ? 19 : 0;
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int w;
    bit closing;
    errors = 0;
    phase = 0;
    idle_cycles = 0;
    accepted_items = 0;
    closing = 1'b0;
    acc_q = 0;
    ctr_q = 0;
    load_ptr = 0;
    halted_q = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.word_in = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].word, directed_rows[i].has_status,
                directed_rows[i].status);

    // Rest of the program image: data words at DATA_LO..DATA_HI, newline filler elsewhere up to the top.
    while (load_ptr < MEM_DEPTH) begin
      w = (load_ptr >= DATA_LO && load_ptr <= DATA_HI) ? data_word() : OP_NEWLINE * 100;
      send_item(1'b0, 16'(w), 1'b0, ST_LOADED);
    end

    while (accepted_items < TOTAL_ITEMS) begin
      phase = (accepted_items * 4) / TOTAL_ITEMS;
      if (accepted_items == TOTAL_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end
      if (!closing && accepted_items >= TAIL_START) begin
        closing = 1'b1;
        plan_stop();
      end
      if ($urandom_range(0, 99) < 4)
        send_item(1'b0, 16'($urandom_range(0, 65535)), 1'b0, ST_LOADED);
      else
        send_item(1'b1, 16'(step_word(closing)), 1'b0, ST_LOADED);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d items through load, self-modifying program loop and a final stop.",
             accepted_items);
    $display("Results by status 0..10: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5], status_seen[6], status_seen[7], status_seen[8], status_seen[9],
             status_seen[10]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
